// ===== rtl/chgs_pkg.sv =====
// Shared types and constants for the Graham scan convex hull block.
// No dependencies; every other file imports this package.
package chgs_pkg;

    localparam int XRES_W   = 64;
    localparam int MIN_HULL = 3;
    localparam int REG_W    = 32;

    localparam logic REG_CROSS_TOL = 1'b0;

    typedef enum logic [5:0] {
        ST_LOAD,
        ST_PIV_RD,
        ST_PIV_CMP,
        ST_PIV_W0,
        ST_PIV_W1,
        ST_SRT_KEY,
        ST_SRT_KEYD,
        ST_SRT_CHK,
        ST_SRT_PRV,
        ST_SRT_C,
        ST_SRT_D1,
        ST_SRT_D2,
        ST_SRT_DEC,
        ST_FLT_RD,
        ST_FLT_CUR,
        ST_FLT_CHK,
        ST_FLT_NXT,
        ST_FLT_C,
        ST_FLT_END,
        ST_SC_I0,
        ST_SC_I1,
        ST_SC_I2,
        ST_SC_CHK,
        ST_SC_CD,
        ST_SC_C,
        ST_SC_PS,
        ST_SC_PD,
        ST_SC_PUSH,
        ST_EH_RD,
        ST_EH_IX,
        ST_EH_LD,
        ST_ER_RD,
        ST_ER_LD,
        ST_OUT_WT
    } state_t;

    typedef struct packed {
        logic valid;
        logic sqdist;
    } xreq_t;

    typedef struct packed {
        logic              valid;
        logic [XRES_W-1:0] value;
    } xres_t;

endpackage

// ===== rtl/chgs_apb.sv =====
// Configuration register file behind an APB-style port.
// Depends on chgs_pkg.
module chgs_apb (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [chgs_pkg::REG_W-1:0] pwdata,
    output logic [chgs_pkg::REG_W-1:0] prdata,
    output logic                      pready,
    output logic [chgs_pkg::REG_W-1:0] tol
);
    import chgs_pkg::*;

    logic [REG_W-1:0] tol_reg;
    logic [REG_W-1:0] tol_next;

    always_comb begin
        tol_next = tol_reg;
        if (psel && penable && pwrite && (paddr[2] == REG_CROSS_TOL)) begin
            tol_next = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= '0;
        end else begin
            tol_reg <= tol_next;
        end
    end

    assign prdata = (paddr[2] == REG_CROSS_TOL) ? tol_reg : '0;
    assign pready = 1'b1;
    assign tol    = tol_reg;

endmodule

// ===== rtl/chgs_cross.sv =====
// Two-stage cross product / squared distance unit, results modulo 2^64.
// Depends on chgs_pkg.
module chgs_cross #(
    parameter int COORD_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  chgs_pkg::xreq_t         req,
    input  logic [2*COORD_BITS-1:0] pa,
    input  logic [2*COORD_BITS-1:0] pb,
    input  logic [2*COORD_BITS-1:0] pc,
    output chgs_pkg::xres_t         res
);
    import chgs_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int DW = CB + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] bx, by, cx, cy;
    logic signed [DW-1:0] u1, v1, u2, v2;
    logic signed [PW-1:0] m1_reg, m2_reg;
    logic signed [PW+XRES_W-1:0] m1e, m2e;
    logic dist_reg, v1_reg, v2_reg;
    logic [XRES_W-1:0] res_reg, res_next;

    assign bx = $signed({pb[2*CB-1], pb[2*CB-1:CB]}) - $signed({pa[2*CB-1], pa[2*CB-1:CB]});
    assign by = $signed({pb[CB-1], pb[CB-1:0]}) - $signed({pa[CB-1], pa[CB-1:0]});
    assign cx = $signed({pc[2*CB-1], pc[2*CB-1:CB]}) - $signed({pa[2*CB-1], pa[2*CB-1:CB]});
    assign cy = $signed({pc[CB-1], pc[CB-1:0]}) - $signed({pa[CB-1], pa[CB-1:0]});

    assign u1 = bx;
    assign v1 = req.sqdist ? bx : cy;
    assign u2 = by;
    assign v2 = req.sqdist ? by : cx;

    assign m1e = m1_reg;
    assign m2e = m2_reg;

    always_comb begin
        if (dist_reg) begin
            res_next = m1e[XRES_W-1:0] + m2e[XRES_W-1:0];
        end else begin
            res_next = m1e[XRES_W-1:0] - m2e[XRES_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        m1_reg   <= u1 * v1;
        m2_reg   <= u2 * v2;
        dist_reg <= req.sqdist;
        res_reg  <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= req.valid;
            v2_reg <= v1_reg;
        end
    end

    assign res.valid = v2_reg;
    assign res.value = res_reg;

endmodule

// ===== rtl/convex_hull_graham_scan.sv =====
// Top level of the Graham scan convex hull block: sequencer, point and stack memories.
// Depends on chgs_pkg, chgs_apb and chgs_cross.
//
//  channel  | handshake          | payload
//  s_       | s_valid / s_ready  | s_coord_x, s_coord_y, s_last_point
//  m_       | m_valid / m_ready  | m_hull_x, m_hull_y, m_hull_last
//  apb      | psel/penable/pready| paddr, pwdata, prdata
//
// Points load one per cycle. After the closing point the block runs pivot search,
// insertion sort, collinear filter and stack scan, stepped through states that are
// paced by the single read port of the point memory and the registered cross unit.
// With fewer than three points loaded, or left after the filter, the points go out
// as they stand in the point memory instead. Each vertex is read (through the stack
// for the hull) into the output register and held until m_ready; s_ready is low until the last vertex is taken.
// Reset clears all control state; no clearing pass.
module convex_hull_graham_scan #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [chgs_pkg::REG_W-1:0]    pwdata,
    output logic [chgs_pkg::REG_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_BITS-1:0]  s_coord_x,
    input  logic signed [COORD_BITS-1:0]  s_coord_y,
    input  logic                          s_last_point,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_BITS-1:0]  m_hull_x,
    output logic signed [COORD_BITS-1:0]  m_hull_y,
    output logic                          m_hull_last
);
    import chgs_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int PTW = 2 * CB;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    state_t state_reg, state_next;

    logic [PTW-1:0] pmem [MAX_POINTS];
    logic [AW-1:0]  smem [MAX_POINTS];

    logic           pm_we;
    logic [AW-1:0]  pm_waddr, pm_raddr;
    logic [PTW-1:0] pm_wdata, pm_rdata;
    logic           sm_we;
    logic [AW-1:0]  sm_waddr, sm_raddr, sm_wdata, sm_rdata;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] mcnt_reg, mcnt_next;
    logic [CW-1:0] d_reg, d_next;
    logic [CW-1:0] e_reg, e_next;
    logic [AW-1:0] piv_reg, piv_next;
    logic          rng_reg, rng_next;
    logic          mv_reg, mv_next;

    logic [PTW-1:0] p0_reg, p0_next;
    logic [PTW-1:0] first_reg, first_next;
    logic [PTW-1:0] key_reg, key_next;
    logic [PTW-1:0] prev_reg, prev_next;
    logic [PTW-1:0] t1_reg, t1_next;
    logic [PTW-1:0] t2_reg, t2_next;
    logic [XRES_W-1:0] d1_reg, d1_next;
    logic          prec_reg, prec_next;
    logic [PTW-1:0] out_reg, out_next;
    logic          olast_reg, olast_next;

    logic [REG_W-1:0] tol;
    xreq_t          xreq;
    xres_t          xres;
    logic [PTW-1:0] xa, xb, xc;

    logic              x_neg, x_col, pless, full, s_fire, m_fire;
    logic [XRES_W-1:0] x_mag;
    logic [CW-1:0]     i_inc, cnt_load, jm1, dm1;

    chgs_apb u_apb (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .tol     (tol)
    );

    chgs_cross #(.COORD_BITS(COORD_BITS)) u_cross (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (xreq),
        .pa      (xa),
        .pb      (xb),
        .pc      (xc),
        .res     (xres)
    );

    always_ff @(posedge aclk) begin
        if (pm_we) begin
            pmem[pm_waddr] <= pm_wdata;
        end
        pm_rdata <= pmem[pm_raddr];
    end

    always_ff @(posedge aclk) begin
        if (sm_we) begin
            smem[sm_waddr] <= sm_wdata;
        end
        sm_rdata <= smem[sm_raddr];
    end

    assign x_neg  = xres.value[XRES_W-1];
    assign x_mag  = x_neg ? (XRES_W'(0) - xres.value) : xres.value;
    assign x_col  = x_mag <= XRES_W'(tol);
    assign pless  = ($signed(pm_rdata[CB-1:0]) < $signed(p0_reg[CB-1:0])) ||
                    ((pm_rdata[CB-1:0] == p0_reg[CB-1:0]) &&
                     ($signed(pm_rdata[PTW-1:CB]) < $signed(p0_reg[PTW-1:CB])));
    assign full   = cnt_reg >= CW'(MAX_POINTS);
    assign s_fire = s_valid && s_ready;
    assign m_fire = mv_reg && m_ready;
    assign i_inc  = i_reg + CW'(1);
    assign cnt_load = full ? cnt_reg : cnt_reg + CW'(1);
    assign jm1    = j_reg - CW'(1);
    assign dm1    = d_reg - CW'(1);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_fire && s_last_point) begin
                    state_next = (cnt_load < CW'(MIN_HULL)) ? ST_ER_RD : ST_PIV_RD;
                end
            end
            ST_PIV_RD:   state_next = ST_PIV_CMP;
            ST_PIV_CMP:  state_next = (i_inc == cnt_reg) ? ST_PIV_W0 : ST_PIV_RD;
            ST_PIV_W0:   state_next = ST_PIV_W1;
            ST_PIV_W1:   state_next = ST_SRT_KEY;
            ST_SRT_KEY:  state_next = ST_SRT_KEYD;
            ST_SRT_KEYD: state_next = ST_SRT_CHK;
            ST_SRT_CHK: begin
                if (j_reg > CW'(1)) begin
                    state_next = ST_SRT_PRV;
                end else begin
                    state_next = (i_inc == cnt_reg) ? ST_FLT_RD : ST_SRT_KEY;
                end
            end
            ST_SRT_PRV:  state_next = ST_SRT_C;
            ST_SRT_C: begin
                if (xres.valid) begin
                    state_next = x_col ? ST_SRT_D1 : ST_SRT_DEC;
                end
            end
            ST_SRT_D1:   if (xres.valid) state_next = ST_SRT_D2;
            ST_SRT_D2:   if (xres.valid) state_next = ST_SRT_DEC;
            ST_SRT_DEC: begin
                if (prec_reg) begin
                    state_next = ST_SRT_CHK;
                end else begin
                    state_next = (i_inc == cnt_reg) ? ST_FLT_RD : ST_SRT_KEY;
                end
            end
            ST_FLT_RD:   state_next = ST_FLT_CUR;
            ST_FLT_CUR:  state_next = ST_FLT_CHK;
            ST_FLT_CHK:  state_next = (i_inc < cnt_reg) ? ST_FLT_NXT : ST_FLT_END;
            ST_FLT_NXT:  state_next = ST_FLT_C;
            ST_FLT_C:    if (xres.valid) state_next = ST_FLT_CHK;
            ST_FLT_END:  state_next = (mcnt_reg < CW'(MIN_HULL)) ? ST_ER_RD : ST_SC_I0;
            ST_SC_I0:    state_next = ST_SC_I1;
            ST_SC_I1:    state_next = ST_SC_I2;
            ST_SC_I2:    state_next = ST_SC_CHK;
            ST_SC_CHK:   state_next = (i_reg < mcnt_reg) ? ST_SC_CD : ST_EH_RD;
            ST_SC_CD:    state_next = ST_SC_C;
            ST_SC_C: begin
                if (xres.valid) begin
                    if (x_neg || x_col) begin
                        state_next = (d_reg >= CW'(MIN_HULL)) ? ST_SC_PS : ST_SC_PUSH;
                    end else begin
                        state_next = ST_SC_PUSH;
                    end
                end
            end
            ST_SC_PS:    state_next = ST_SC_PD;
            ST_SC_PD:    state_next = ST_SC_C;
            ST_SC_PUSH:  state_next = ST_SC_CHK;
            ST_EH_RD:    state_next = ST_EH_IX;
            ST_EH_IX:    state_next = ST_EH_LD;
            ST_EH_LD:    state_next = ST_OUT_WT;
            ST_ER_RD:    state_next = ST_ER_LD;
            ST_ER_LD:    state_next = ST_OUT_WT;
            ST_OUT_WT: begin
                if (m_fire) begin
                    if (olast_reg) begin
                        state_next = ST_LOAD;
                    end else begin
                        state_next = rng_reg ? ST_ER_RD : ST_EH_RD;
                    end
                end
            end
            default:     state_next = ST_LOAD;
        endcase
    end

    always_comb begin
        pm_we = 1'b0; pm_waddr = '0; pm_wdata = '0; pm_raddr = '0;
        sm_we = 1'b0; sm_waddr = '0; sm_wdata = '0; sm_raddr = '0;
        xreq = '0; xa = p0_reg; xb = key_reg; xc = pm_rdata;
        cnt_next = cnt_reg; i_next = i_reg; j_next = j_reg; mcnt_next = mcnt_reg;
        d_next = d_reg; e_next = e_reg; piv_next = piv_reg; rng_next = rng_reg;
        mv_next = mv_reg; p0_next = p0_reg; first_next = first_reg;
        key_next = key_reg; prev_next = prev_reg; t1_next = t1_reg; t2_next = t2_reg;
        d1_next = d1_reg; prec_next = prec_reg; out_next = out_reg;
        olast_next = olast_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_fire) begin
                    if (!full) begin
                        pm_we    = 1'b1;
                        pm_waddr = cnt_reg[AW-1:0];
                        pm_wdata = {s_coord_x, s_coord_y};
                    end
                    cnt_next = cnt_load;
                    i_next   = '0;
                    e_next   = '0;
                    d_next   = cnt_load;
                    rng_next = 1'b1;
                end
            end
            ST_PIV_RD: pm_raddr = i_reg[AW-1:0];
            ST_PIV_CMP: begin
                if (i_reg == '0) begin
                    first_next = pm_rdata;
                end
                if ((i_reg == '0) || pless) begin
                    p0_next  = pm_rdata;
                    piv_next = i_reg[AW-1:0];
                end
                i_next = i_inc;
            end
            ST_PIV_W0: begin
                pm_we = 1'b1; pm_waddr = '0; pm_wdata = p0_reg;
            end
            ST_PIV_W1: begin
                pm_we = 1'b1; pm_waddr = piv_reg; pm_wdata = first_reg;
                i_next = CW'(2);
            end
            ST_SRT_KEY: pm_raddr = i_reg[AW-1:0];
            ST_SRT_KEYD: begin
                key_next = pm_rdata;
                j_next   = i_reg;
            end
            ST_SRT_CHK: begin
                if (j_reg > CW'(1)) begin
                    pm_raddr = jm1[AW-1:0];
                end else begin
                    pm_we = 1'b1; pm_waddr = j_reg[AW-1:0]; pm_wdata = key_reg;
                    i_next = i_inc;
                    if (i_inc == cnt_reg) begin
                        i_next = CW'(1); mcnt_next = CW'(1);
                    end
                end
            end
            ST_SRT_PRV: begin
                prev_next = pm_rdata;
                xreq.valid = 1'b1;
            end
            ST_SRT_C: begin
                if (xres.valid) begin
                    prec_next = !x_neg;
                    if (x_col) begin
                        xreq.valid = 1'b1; xreq.sqdist = 1'b1;
                    end
                end
            end
            ST_SRT_D1: begin
                if (xres.valid) begin
                    d1_next = xres.value;
                    xreq.valid = 1'b1; xreq.sqdist = 1'b1; xb = prev_reg;
                end
            end
            ST_SRT_D2: begin
                if (xres.valid) begin
                    prec_next = d1_reg < xres.value;
                end
            end
            ST_SRT_DEC: begin
                pm_we = 1'b1; pm_waddr = j_reg[AW-1:0];
                if (prec_reg) begin
                    pm_wdata = prev_reg;
                    j_next   = jm1;
                end else begin
                    pm_wdata = key_reg;
                    i_next   = i_inc;
                    if (i_inc == cnt_reg) begin
                        i_next = CW'(1); mcnt_next = CW'(1);
                    end
                end
            end
            ST_FLT_RD: pm_raddr = i_reg[AW-1:0];
            ST_FLT_CUR: key_next = pm_rdata;
            ST_FLT_CHK: begin
                if (i_inc < cnt_reg) begin
                    pm_raddr = i_inc[AW-1:0];
                end else begin
                    pm_we = 1'b1; pm_waddr = mcnt_reg[AW-1:0]; pm_wdata = key_reg;
                    mcnt_next = mcnt_reg + CW'(1);
                end
            end
            ST_FLT_NXT: begin
                prev_next  = pm_rdata;
                xreq.valid = 1'b1;
            end
            ST_FLT_C: begin
                if (xres.valid) begin
                    if (!x_col) begin
                        pm_we = 1'b1; pm_waddr = mcnt_reg[AW-1:0]; pm_wdata = key_reg;
                        mcnt_next = mcnt_reg + CW'(1);
                    end
                    key_next = prev_reg;
                    i_next   = i_inc;
                end
            end
            ST_FLT_END: begin
                e_next = '0;
                d_next = mcnt_reg;
                rng_next = 1'b1;
            end
            ST_SC_I0: begin
                sm_we = 1'b1; sm_waddr = '0; sm_wdata = '0;
                pm_raddr = AW'(1);
            end
            ST_SC_I1: begin
                t2_next = pm_rdata;
                sm_we = 1'b1; sm_waddr = AW'(1); sm_wdata = AW'(1);
                pm_raddr = AW'(2);
            end
            ST_SC_I2: begin
                t1_next = pm_rdata;
                sm_we = 1'b1; sm_waddr = AW'(2); sm_wdata = AW'(2);
                d_next = CW'(MIN_HULL);
                i_next = CW'(MIN_HULL);
            end
            ST_SC_CHK: begin
                pm_raddr = i_reg[AW-1:0];
                e_next   = '0;
                rng_next = 1'b0;
            end
            ST_SC_CD: begin
                key_next = pm_rdata;
                xreq.valid = 1'b1; xa = t2_reg; xb = t1_reg; xc = pm_rdata;
            end
            ST_SC_C: begin
                if (xres.valid && (x_neg || x_col)) begin
                    d_next  = dm1;
                    t1_next = t2_reg;
                    sm_raddr = AW'(d_reg - CW'(MIN_HULL));
                end
            end
            ST_SC_PS: pm_raddr = sm_rdata;
            ST_SC_PD: begin
                t2_next = pm_rdata;
                xreq.valid = 1'b1; xa = pm_rdata; xb = t1_reg; xc = key_reg;
            end
            ST_SC_PUSH: begin
                sm_we = 1'b1; sm_waddr = d_reg[AW-1:0]; sm_wdata = i_reg[AW-1:0];
                d_next  = d_reg + CW'(1);
                t2_next = t1_reg;
                t1_next = key_reg;
                i_next  = i_inc;
            end
            ST_EH_RD: sm_raddr = e_reg[AW-1:0];
            ST_EH_IX: pm_raddr = sm_rdata;
            ST_EH_LD, ST_ER_LD: begin
                out_next   = pm_rdata;
                olast_next = (e_reg + CW'(1)) == d_reg;
                mv_next    = 1'b1;
            end
            ST_ER_RD: pm_raddr = e_reg[AW-1:0];
            ST_OUT_WT: begin
                if (m_fire) begin
                    mv_next = 1'b0;
                    e_next  = e_reg + CW'(1);
                    if (olast_reg) begin
                        cnt_next = '0;
                    end
                end
            end
            default: begin
                mv_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            mcnt_reg  <= '0;
            d_reg     <= '0;
            e_reg     <= '0;
            piv_reg   <= '0;
            rng_reg   <= 1'b0;
            mv_reg    <= 1'b0;
            prec_reg  <= 1'b0;
            olast_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            mcnt_reg  <= mcnt_next;
            d_reg     <= d_next;
            e_reg     <= e_next;
            piv_reg   <= piv_next;
            rng_reg   <= rng_next;
            mv_reg    <= mv_next;
            prec_reg  <= prec_next;
            olast_reg <= olast_next;
        end
    end

    always_ff @(posedge aclk) begin
        p0_reg    <= p0_next;
        first_reg <= first_next;
        key_reg   <= key_next;
        prev_reg  <= prev_next;
        t1_reg    <= t1_next;
        t2_reg    <= t2_next;
        d1_reg    <= d1_next;
        out_reg   <= out_next;
    end

    assign s_ready     = (state_reg == ST_LOAD);
    assign m_valid     = mv_reg;
    assign m_hull_x    = out_reg[PTW-1:CB];
    assign m_hull_y    = out_reg[CB-1:0];
    assign m_hull_last = olast_reg;

`ifndef SYNTHESIS
    a_no_load_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !mv_reg)
        else $error("input taken while a result is pending");
    a_cross_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        xres.valid |-> $past(xreq.valid, 2))
        else $error("cross result without request");
    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        d_reg <= CW'(MAX_POINTS))
        else $error("stack depth beyond store");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_POINTS))
        else $error("point count beyond store");
`endif

endmodule
